/* rtl/frm_rot_pkg.sv */
// ---------------------------------------------------------------------------
// frm_rot_pkg
// Shared types and constants of the quarter-turn frame rotator.
// ---------------------------------------------------------------------------
package frm_rot_pkg;

   // frame geometry limits
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int DIM_W      = 9;    // width of the frame_width/frame_height registers
   localparam int IDX_W      = 8;    // row and column counters
   localparam int ADDR_W     = 16;   // frame store address
   localparam int PIX_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int PROD_W     = IDX_W + DIM_W;

   localparam logic [DIM_W-1:0] MAX_WIDTH_VAL  = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_HEIGHT_VAL = DIM_W'(MAX_HEIGHT);

   // rotation codes
   typedef enum logic [1:0] {
      ROT_NONE = 2'd0,
      ROT_90   = 2'd1,
      ROT_180  = 2'd2,
      ROT_270  = 2'd3
   } rot_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 2'd2;

   // action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_FETCH = 1'b1;

   // configuration as seen by the address generator (dimensions already clamped)
   typedef struct packed {
      rot_type            mode;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
   } cfg_type;

   // read request from the address generator to the store
   typedef struct packed {
      logic               s1_busy;
      logic               valid;
      logic [ADDR_W-1:0]  addr;
      logic               last;
   } rd_req_type;

endpackage

/* rtl/frm_rot_req_if.sv */
// ---------------------------------------------------------------------------
// frm_rot_req_if
// Request channel: write or fetch transactions with valid/ready handshake.
// ---------------------------------------------------------------------------
interface frm_rot_req_if;
   import frm_rot_pkg::*;

   logic             valid;
   logic             ready;
   logic             action;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output action, output pixel_in, input ready);
   modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

/* rtl/frm_rot_rsp_if.sv */
// ---------------------------------------------------------------------------
// frm_rot_rsp_if
// Response channel: rotated pixels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface frm_rot_rsp_if;
   import frm_rot_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

/* rtl/frm_rot_store.sv */
// ---------------------------------------------------------------------------
// frm_rot_store
// Frame store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module frm_rot_store (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [frm_rot_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [frm_rot_pkg::PIX_W-1:0]   wr_data,
   input  logic                            rd_en,
   input  logic [frm_rot_pkg::ADDR_W-1:0]  rd_addr,
   output logic [frm_rot_pkg::PIX_W-1:0]   rd_data
);
   import frm_rot_pkg::*;

   logic [PIX_W-1:0] mem [0:MAX_WIDTH*MAX_HEIGHT-1];
   logic [PIX_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/frm_rot_agen.sv */
// ---------------------------------------------------------------------------
// frm_rot_agen
// Address generator: load counter, output row/column counters and the
// two-stage rotated address computation (operand select, multiply-add).
// ---------------------------------------------------------------------------
module frm_rot_agen (
   input  logic                            clock,
   input  logic                            reset,
   input  frm_rot_pkg::cfg_type            cfg,
   input  logic                            wr_go,
   input  logic                            fetch_go,
   output logic [frm_rot_pkg::ADDR_W-1:0]  wr_addr,
   output frm_rot_pkg::rd_req_type         rd_req
);
   import frm_rot_pkg::*;

   logic [ADDR_W-1:0]   load_ff, load_in, load_cur;
   logic [2*DIM_W-1:0]  frame_size;
   logic [2*DIM_W-1:0]  load_nxt;
   logic [IDX_W-1:0]    row_ff, row_in, col_ff, col_in;
   logic [IDX_W-1:0]    row_cur, col_cur;
   logic                pos_restart;
   logic [DIM_W-1:0]    row_nxt, col_nxt;
   logic [DIM_W-1:0]    w_m1, h_m1;
   logic [IDX_W-1:0]    col_rev, row_rev;
   logic [IDX_W-1:0]    op_a;
   logic [DIM_W-1:0]    op_b;
   logic [IDX_W-1:0]    op_d;
   logic                pos_last;

   logic                s1_v_ff, s1_v_in;
   logic [IDX_W-1:0]    mul_a_ff;
   logic [DIM_W-1:0]    mul_b_ff;
   logic [IDX_W-1:0]    add_d_ff;
   logic                s1_last_ff;

   logic [PROD_W-1:0]   prod;
   logic [PROD_W:0]     addr_sum;
   logic                rd_v_ff, rd_v_in;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic                rd_last_ff;

   // load counter with wrap at width*height
   assign frame_size = cfg.width * cfg.height;
   assign load_cur   = ({2'b00, load_ff} >= frame_size) ? '0 : load_ff;
   assign load_nxt   = {2'b00, load_cur} + (2*DIM_W)'(1);
   assign load_in    = !wr_go ? load_ff :
                       (load_nxt >= frame_size) ? '0 : load_nxt[ADDR_W-1:0];
   assign wr_addr    = load_cur;

   // output position, restarted when outside the current geometry
   assign pos_restart = ({1'b0, row_ff} >= cfg.height) || ({1'b0, col_ff} >= cfg.width);
   assign row_cur     = pos_restart ? '0 : row_ff;
   assign col_cur     = pos_restart ? '0 : col_ff;
   assign row_nxt     = {1'b0, row_cur} + DIM_W'(1);
   assign col_nxt     = {1'b0, col_cur} + DIM_W'(1);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (fetch_go) begin
         if (col_nxt >= cfg.width) begin
            col_in = '0;
            row_in = (row_nxt >= cfg.height) ? '0 : row_nxt[IDX_W-1:0];
         end else begin
            row_in = row_cur;
            col_in = col_nxt[IDX_W-1:0];
         end
      end
   end

   // mirrored coordinates
   assign w_m1     = cfg.width - DIM_W'(1);
   assign h_m1     = cfg.height - DIM_W'(1);
   assign col_rev  = w_m1[IDX_W-1:0] - col_cur;
   assign row_rev  = h_m1[IDX_W-1:0] - row_cur;
   assign pos_last = (row_cur == h_m1[IDX_W-1:0]) && (col_cur == w_m1[IDX_W-1:0]);

   // source address = op_a * op_b + op_d
   always_comb begin
      unique case (cfg.mode)
         ROT_90: begin
            op_a = col_rev;
            op_b = cfg.height;
            op_d = row_cur;
         end
         ROT_180: begin
            op_a = row_rev;
            op_b = cfg.width;
            op_d = col_rev;
         end
         ROT_270: begin
            op_a = col_cur;
            op_b = cfg.height;
            op_d = row_rev;
         end
         default: begin
            op_a = row_cur;
            op_b = cfg.width;
            op_d = col_cur;
         end
      endcase
   end

   // stage 2: multiply-add into the read address
   assign prod     = mul_a_ff * mul_b_ff;
   assign addr_sum = {1'b0, prod} + {{(PROD_W+1-IDX_W){1'b0}}, add_d_ff};

   assign s1_v_in = fetch_go;
   assign rd_v_in = s1_v_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
         s1_v_ff <= 1'b0;
         rd_v_ff <= 1'b0;
      end else begin
         load_ff <= load_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         s1_v_ff <= s1_v_in;
         rd_v_ff <= rd_v_in;
      end
   end

   // operand and address payload
   always_ff @(posedge clock) begin
      if (fetch_go) begin
         mul_a_ff   <= op_a;
         mul_b_ff   <= op_b;
         add_d_ff   <= op_d;
         s1_last_ff <= pos_last;
      end
      if (s1_v_ff) begin
         rd_addr_ff <= addr_sum[ADDR_W-1:0];
         rd_last_ff <= s1_last_ff;
      end
   end

   assign rd_req.s1_busy = s1_v_ff;
   assign rd_req.valid   = rd_v_ff;
   assign rd_req.addr    = rd_addr_ff;
   assign rd_req.last    = rd_last_ff;
endmodule

/* rtl/frame_rotate_by_quarter_turns.sv */
// ---------------------------------------------------------------------------
// frame_rotate_by_quarter_turns
// Loads a frame into the frame store and reads it back rotated by 0, 90,
// 180 or 270 degrees in output raster order.
//
//   channel   direction   handshake       payload
//   req_ch    in          valid/ready     action, pixel_in
//   rsp_ch    out         valid/ready     pixel_out, frame_last
//   csr_*     in          write enable    csr_index, csr_wdata
//
// A write transaction stores its pixel and returns nothing.
// A fetch transaction shows its pixel after acceptance through operand
// select, multiply-add of the address, store read and output register; the
// next transaction is taken once that pixel sits in the output register.
// Reset clears counters and valid flags, presets the CSRs, keeps the store.
// A stalled output holds its pixel; one more fetch can finish behind it.
// ---------------------------------------------------------------------------
module frame_rotate_by_quarter_turns (
   input  logic                                 clock,
   input  logic                                 reset,
   frm_rot_req_if.sink                          req_ch,
   frm_rot_rsp_if.source                        rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [frm_rot_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [frm_rot_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import frm_rot_pkg::*;

   rot_type             mode_ff, mode_in;
   logic [DIM_W-1:0]    width_ff, width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [DIM_W-1:0]    width_clamp, height_clamp;
   cfg_type             cfg;

   logic                req_take;
   logic                wr_go, fetch_go;
   logic                busy;
   logic [ADDR_W-1:0]   wr_addr;
   rd_req_type          rd_req;
   logic [PIX_W-1:0]    rd_data;

   logic                s3_v_ff, s3_v_in;
   logic                s3_last_ff;
   logic                out_load;
   logic                rsp_v_ff, rsp_v_in;
   logic [PIX_W-1:0]    pix_ff;
   logic                last_ff;

   // register writes, dimensions clamped to 1..max
   assign width_clamp  = (csr_wdata == '0) ? DIM_W'(1) :
                         (csr_wdata > MAX_WIDTH_VAL) ? MAX_WIDTH_VAL : csr_wdata;
   assign height_clamp = (csr_wdata == '0) ? DIM_W'(1) :
                         (csr_wdata > MAX_HEIGHT_VAL) ? MAX_HEIGHT_VAL : csr_wdata;

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROTATION: mode_in   = rot_type'(csr_wdata[1:0]);
            CSR_WIDTH:    width_in  = width_clamp;
            CSR_HEIGHT:   height_in = height_clamp;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ROT_NONE;
         width_ff  <= MAX_WIDTH_VAL;
         height_ff <= MAX_HEIGHT_VAL;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign cfg.mode   = mode_ff;
   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;

   // request acceptance, one fetch in flight at a time
   assign busy         = rd_req.s1_busy | rd_req.valid | s3_v_ff;
   assign req_ch.ready = !busy;
   assign req_take     = req_ch.valid && !busy;
   assign wr_go        = req_take && (req_ch.action == ACT_WRITE);
   assign fetch_go     = req_take && (req_ch.action == ACT_FETCH);

   frm_rot_agen u_agen (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .wr_go    (wr_go),
      .fetch_go (fetch_go),
      .wr_addr  (wr_addr),
      .rd_req   (rd_req)
   );

   frm_rot_store u_store (
      .clock   (clock),
      .wr_en   (wr_go),
      .wr_addr (wr_addr),
      .wr_data (req_ch.pixel_in),
      .rd_en   (rd_req.valid),
      .rd_addr (rd_req.addr),
      .rd_data (rd_data)
   );

   // read data stage, waits for the output register
   assign out_load = s3_v_ff && (!rsp_v_ff || rsp_ch.ready);
   assign s3_v_in  = rd_req.valid || (s3_v_ff && !out_load);
   assign rsp_v_in = out_load || (rsp_v_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s3_v_ff  <= s3_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (rd_req.valid) begin
         s3_last_ff <= rd_req.last;
      end
      if (out_load) begin
         pix_ff  <= rd_data;
         last_ff <= s3_last_ff;
      end
   end

   assign rsp_ch.valid      = rsp_v_ff;
   assign rsp_ch.pixel_out  = pix_ff;
   assign rsp_ch.frame_last = last_ff;

`ifndef SYNTH
   // never more than one fetch inside the pipeline
   a_single_fetch: assert property (@(posedge clock) disable iff (reset)
      $onehot0({rd_req.s1_busy, rd_req.valid, s3_v_ff}))
      else $error("more than one fetch in flight");

   // an accepted fetch reaches the read data stage via stage 1 and the read request
   a_fetch_latency: assert property (@(posedge clock) disable iff (reset)
      fetch_go |-> ##3 s3_v_ff)
      else $error("fetch did not reach read data stage");

   // read data moves on at once when the output register is free
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && !rsp_v_ff) |=> (!s3_v_ff && rsp_v_ff))
      else $error("read data held while output register empty");

   // a write never coincides with a fetch in flight
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_go |-> !(rd_req.s1_busy || rd_req.valid || s3_v_ff))
      else $error("write taken while fetch in flight");
`endif
endmodule
